/* hw/rtl/moi_pkg.sv */
// Package for the mecanum odometry integrator: item structs, sequencer states,
// register indexes, reset values and angle constants. No dependencies.
package moi_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int SINE_DEPTH_DEF  = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DPC      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD_SCL  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STR_SCL  = 3'd6;

	localparam logic [23:0] DPC_RESET   = 24'd793047;
	localparam logic [14:0] GAIN_RESET  = 15'd16384;
	localparam logic [15:0] FSCL_RESET  = 16'd32276;
	localparam logic [15:0] SSCL_RESET  = 16'd31457;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	localparam int HALF_TURN_UNITS = 23040;
	localparam int TURN_UNITS      = 46080;
	localparam int FULL_HALF_UNITS = 92160;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

	// multiply sequence: four count scalings, four gains, fwd, str, four rotations
	localparam logic [3:0] SEQ_DPC0  = 4'd0;
	localparam logic [3:0] SEQ_GAIN0 = 4'd4;
	localparam logic [3:0] SEQ_FWD   = 4'd8;
	localparam logic [3:0] SEQ_STR   = 4'd9;
	localparam logic [3:0] SEQ_XC    = 4'd10;
	localparam logic [3:0] SEQ_XS    = 4'd11;
	localparam logic [3:0] SEQ_YS    = 4'd12;
	localparam logic [3:0] SEQ_YC    = 4'd13;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TRIG,
		ST_LOAD,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] count_fl;
		logic signed [31:0] count_fr;
		logic signed [31:0] count_rl;
		logic signed [31:0] count_rr;
		logic signed [15:0] yaw_in;
		logic signed [31:0] set_x;
		logic signed [31:0] set_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_yaw;
	} out_item_t;

endpackage

/* hw/rtl/mecanum_odometry_integrator_unit.sv */
// Mecanum odometry integrator top level; uses moi_pkg.
// Load item: result registered in the cycle after the transfer. Update item: result after the
// divide (11 divide steps at depth 1024), sequencing, and the bit-serial multiplier for
// fourteen products. One item in flight; with no output stall the next transfer can be
// taken in the same cycle as the result is presented.
// Reset (arst_n low, asynchronous) clears pose, heading, last counts, output valid; loads defaults.
module mecanum_odometry_integrator_unit import moi_pkg::*; #(
	parameter int COUNT_WIDTH      = COUNT_WIDTH_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW   = COUNT_WIDTH;
	localparam int NW   = $clog2(SINE_TABLE_DEPTH);
	localparam int QW   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int NUMW = $clog2(FULL_HALF_UNITS * (SINE_TABLE_DEPTH + 1));
	localparam int DIVW = NUMW + QW;
	localparam int DCW  = $clog2(QW);
	localparam int QD   = SINE_TABLE_DEPTH / 4;
	localparam int QJW  = NW - 1;

	function automatic longint wave_q16(input longint unsigned m);
		longint unsigned quad, r, x, a, term;
		longint sum, q;
		quad = (m / SINE_TABLE_DEPTH) & 64'd3;
		r    = m % SINE_TABLE_DEPTH;
		x    = quad[0] ? (SINE_TABLE_DEPTH - r) : r;
		a    = (HALF_PI_Q30 * x + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		term = a;
		sum  = longint'(a);
		for (int k = 0; k < 7; k++) begin
			term = (term * a) >> 30;
			term = (term * a) >> 30;
			term = term / TAYLOR_DIV[k];
			if (k % 2 == 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		q = (sum + 64'sd8192) >>> 14;
		return quad[1] ? -q : q;
	endfunction

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	localparam logic [16:0] QPEAK = 17'(wave_q16(longint'(SINE_TABLE_DEPTH)));

	// quarter-wave magnitudes; the peak entry stands apart
	logic [16:0] qrom [QD];

	for (genvar g = 0; g < QD; g++) begin : g_rom
		assign qrom[g] = 17'(wave_q16(longint'(4 * g)));
	end

	state_t state_q, state_nx;

	logic [23:0]        dpc_q;
	logic [14:0]        gain_q [4];
	logic [15:0]        fscl_q, sscl_q;
	logic [CW-1:0]      last_q [4];
	logic [CW-1:0]      delta_q [4];
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [15:0]        heading_q;
	out_item_t          out_q;
	logic               out_valid_q;
	logic [3:0]         seq_q;

	logic [NUMW-1:0]    rem_q;
	logic [QW-1:0]      quo_q;
	logic [DCW-1:0]     dcnt_q;
	logic signed [17:0] sn_q, cs_q;
	logic signed [63:0] a_q, acc_q, t_q, fwd_q, str_q, dx_q, dy_q;
	logic signed [24:0] b_q;
	logic [4:0]         bits_q;
	logic signed [63:0] w_q [4];

	logic               in_acc, mul_last, out_set;
	logic [CW-1:0]      cnt_in [4];
	logic signed [17:0] yd_raw, yd;
	logic signed [18:0] mid;
	logic [16:0]        midm;
	logic [NUMW-1:0]    num;
	logic [DIVW-1:0]    dsh;
	logic               dfit;
	logic [NW-1:0]      idx;
	logic [NW-1:0]      tn [2];
	logic [QJW-1:0]     tj [2];
	logic [16:0]        tm [2];
	logic signed [17:0] tv [2];
	logic signed [63:0] a_sel, pp, acc_nx, wsum, wdif;
	logic signed [24:0] b_sel;
	logic [4:0]         nb;
	logic signed [31:0] sat_x, sat_y;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_acc    = in_valid && !in_stall;
	assign mul_last  = (state_q == ST_MUL) && (bits_q == 5'd0);
	assign out_set   = (in_acc && in_data.opcode == OP_LOAD) || (state_q == ST_FIN);

	assign cnt_in[0] = in_data.count_fl[CW-1:0];
	assign cnt_in[1] = in_data.count_fr[CW-1:0];
	assign cnt_in[2] = in_data.count_rl[CW-1:0];
	assign cnt_in[3] = in_data.count_rr[CW-1:0];

	// yaw delta wrap, midpoint in 1/256 degree, numerator of the table index
	always_comb begin
		yd_raw = {{2{in_data.yaw_in[15]}}, in_data.yaw_in} - {{2{heading_q[15]}}, heading_q};
		if (yd_raw > $signed(18'(HALF_TURN_UNITS))) yd = yd_raw - $signed(18'(TURN_UNITS));
		else if (yd_raw < -$signed(18'(HALF_TURN_UNITS)))
			yd = yd_raw + $signed(18'(TURN_UNITS));
		else yd = yd_raw;
		mid = {{2{heading_q[15]}}, heading_q, 1'b0} + {yd[17], yd};
		if (mid < 0) midm = 17'(mid + $signed(19'(FULL_HALF_UNITS)));
		else midm = 17'(mid);
		num = NUMW'(32'(midm) * 32'(SINE_TABLE_DEPTH) + 32'(FULL_HALF_UNITS / 2));
	end

	assign dsh  = DIVW'(FULL_HALF_UNITS) << dcnt_q;
	assign dfit = {{QW{1'b0}}, rem_q} >= dsh;
	assign idx  = (quo_q == QW'(SINE_TABLE_DEPTH)) ? '0 : quo_q[NW-1:0];

	// fold sine and cosine phases onto the quarter wave
	always_comb begin
		tn[0] = idx;
		tn[1] = idx + NW'(QD);
		for (int l = 0; l < 2; l++) begin
			if (tn[l][NW-2]) tj[l] = QJW'(QD) - {1'b0, tn[l][NW-3:0]};
			else tj[l] = {1'b0, tn[l][NW-3:0]};
			tm[l] = (tj[l] == QJW'(QD)) ? QPEAK : qrom[tj[l][NW-3:0]];
			tv[l] = tn[l][NW-1] ? -$signed({1'b0, tm[l]}) : $signed({1'b0, tm[l]});
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		wsum  = w_q[0] + w_q[1] + w_q[2] + w_q[3];
		wdif  = -w_q[0] + w_q[1] + w_q[2] - w_q[3];
		a_sel = '0;
		b_sel = '0;
		nb    = '0;
		if (seq_q < SEQ_GAIN0) begin
			a_sel = {{(64-CW){delta_q[seq_q[1:0]][CW-1]}}, delta_q[seq_q[1:0]]};
			b_sel = {1'b0, dpc_q};
			nb    = 5'd24;
		end else if (seq_q < SEQ_FWD) begin
			a_sel = w_q[seq_q[1:0]];
			b_sel = {10'd0, gain_q[seq_q[1:0]]};
			nb    = 5'd15;
		end else begin
			case (seq_q)
				SEQ_FWD: begin a_sel = wsum; b_sel = {9'd0, fscl_q}; nb = 5'd16; end
				SEQ_STR: begin a_sel = wdif; b_sel = {9'd0, sscl_q}; nb = 5'd16; end
				SEQ_XC:  begin a_sel = fwd_q; b_sel = {{7{cs_q[17]}}, cs_q}; nb = 5'd17; end
				SEQ_XS:  begin a_sel = str_q; b_sel = {{7{sn_q[17]}}, sn_q}; nb = 5'd17; end
				SEQ_YS:  begin a_sel = fwd_q; b_sel = {{7{sn_q[17]}}, sn_q}; nb = 5'd17; end
				SEQ_YC:  begin a_sel = str_q; b_sel = {{7{cs_q[17]}}, cs_q}; nb = 5'd17; end
				default: begin a_sel = '0; b_sel = '0; nb = '0; end
			endcase
		end
	end

	// top multiplier bit carries negative weight
	assign pp     = b_q[0] ? a_q : '0;
	assign acc_nx = (bits_q == 5'd0) ? acc_q - pp : acc_q + pp;

	assign sat_x = sat32(64'(pos_x_q) + dx_q);
	assign sat_y = sat32(64'(pos_y_q) + dy_q);

	always_comb begin
		state_nx = state_q;
		in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
		case (state_q)
			ST_IDLE: if (in_valid && !in_stall && in_data.opcode == OP_UPDATE) begin
				state_nx = ST_DIV;
			end
			ST_DIV:  if (dcnt_q == '0) state_nx = ST_TRIG;
			ST_TRIG: state_nx = ST_LOAD;
			ST_LOAD: state_nx = ST_MUL;
			ST_MUL:  if (bits_q == 5'd0) begin
				state_nx = (seq_q == SEQ_YC) ? ST_FIN : ST_LOAD;
			end
			ST_FIN:  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q       <= DPC_RESET;
			gain_q      <= '{GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET};
			fscl_q      <= FSCL_RESET;
			sscl_q      <= SSCL_RESET;
			last_q      <= '{'0, '0, '0, '0};
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			seq_q       <= '0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DPC:     dpc_q     <= cfg_data[23:0];
					CFG_GAIN_FL: gain_q[0] <= cfg_data[14:0];
					CFG_GAIN_FR: gain_q[1] <= cfg_data[14:0];
					CFG_GAIN_RL: gain_q[2] <= cfg_data[14:0];
					CFG_GAIN_RR: gain_q[3] <= cfg_data[14:0];
					CFG_FWD_SCL: fscl_q    <= cfg_data[15:0];
					CFG_STR_SCL: sscl_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				for (int i = 0; i < 4; i++) last_q[i] <= cnt_in[i];
				heading_q <= in_data.yaw_in;
				seq_q     <= SEQ_DPC0;
				if (in_data.opcode == OP_LOAD) begin
					pos_x_q <= in_data.set_x;
					pos_y_q <= in_data.set_y;
					out_q   <= '{in_data.set_x, in_data.set_y, in_data.yaw_in};
				end
			end
			if (mul_last) seq_q <= seq_q + 4'd1;
			if (state_q == ST_FIN) begin
				pos_x_q <= sat_x;
				pos_y_q <= sat_y;
				out_q   <= '{sat_x, sat_y, heading_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				for (int i = 0; i < 4; i++) delta_q[i] <= cnt_in[i] - last_q[i];
				rem_q  <= num;
				quo_q  <= '0;
				dcnt_q <= DCW'(QW - 1);
			end
			ST_DIV: begin
				if (dfit) begin
					rem_q         <= rem_q - dsh[NUMW-1:0];
					quo_q[dcnt_q] <= 1'b1;
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_TRIG: begin
				sn_q <= tv[0];
				cs_q <= tv[1];
			end
			ST_LOAD: begin
				a_q    <= a_sel;
				b_q    <= b_sel;
				bits_q <= nb;
				acc_q  <= '0;
			end
			ST_MUL: begin
				acc_q  <= acc_nx;
				a_q    <= a_q <<< 1;
				b_q    <= b_q >>> 1;
				bits_q <= bits_q - 5'd1;
				if (bits_q == 5'd0) begin
					if (seq_q < SEQ_GAIN0) w_q[seq_q[1:0]] <= rnd(acc_nx, 12);
					else if (seq_q < SEQ_FWD) w_q[seq_q[1:0]] <= rnd(acc_nx, 14);
					else begin
						case (seq_q)
							SEQ_FWD: fwd_q <= rnd(acc_nx, 17);
							SEQ_STR: str_q <= rnd(acc_nx, 17);
							SEQ_XC:  t_q   <= acc_nx;
							SEQ_XS:  dx_q  <= rnd(t_q - acc_nx, 24);
							SEQ_YS:  t_q   <= acc_nx;
							SEQ_YC:  dy_q  <= rnd(t_q + acc_nx, 24);
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	a_fin_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !out_valid_q)
		else $error("finish step found the output register occupied");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && bits_q != 5'd0) |=>
		(state_q == ST_MUL && bits_q == $past(bits_q) - 5'd1))
		else $error("multiplier bit count broke off early");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRIG |-> quo_q <= QW'(SINE_TABLE_DEPTH))
		else $error("table index quotient out of range");

	a_seq_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_MUL) |-> seq_q <= SEQ_YC)
		else $error("multiply sequence ran past its end");

endmodule
